// ===== src/hrse_pkg.sv =====
package hrse_pkg;

  localparam int unsigned FACTOR_W    = 17;
  localparam int unsigned TIMER_W     = 26;
  localparam int unsigned MS_W        = 16;
  localparam int unsigned ELAPSED_W   = 20;
  localparam int unsigned TICK_W      = 18;
  localparam int unsigned STRENGTH_W  = 16;
  localparam int unsigned QUOT_W      = 16;
  localparam int unsigned PROD_W      = TIMER_W + QUOT_W;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 17;
  localparam int unsigned PHASE_W     = 2;

  localparam logic [FACTOR_W-1:0]  Q_ONE        = 17'd65536;
  localparam logic [FACTOR_W-1:0]  SCALE_MIN    = 17'd3277;
  localparam logic [FACTOR_W-1:0]  SCALE_RESET  = 17'd16384;
  localparam logic [MS_W-1:0]      HOLD_MS_RESET   = 16'd700;
  localparam logic [MS_W-1:0]      RAMP_MS_RESET   = 16'd900;
  localparam logic [MS_W-1:0]      THRESHOLD_RESET = 16'd100;
  localparam logic [ELAPSED_W-1:0] LONG_TICK_US = 20'd250000;
  localparam logic [9:0]           US_PER_MS    = 10'd1000;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_TRIGGER = 1'b1;

  localparam logic [PHASE_W-1:0] PHASE_IDLE = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_HOLD = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_RAMP = 2'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ENABLED    = 3'd0,
    REG_SLOW_SCALE = 3'd1,
    REG_HOLD_TIME  = 3'd2,
    REG_RAMP_TIME  = 3'd3,
    REG_THRESHOLD  = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic                  enabled;
    logic [FACTOR_W-1:0]   slow_scale;
    logic [TIMER_W-1:0]    hold_us;
    logic [TIMER_W-1:0]    ramp_us;
    logic [STRENGTH_W-1:0] threshold;
  } cfg_t;

  function automatic logic [TIMER_W-1:0] us_from_ms(input logic [MS_W-1:0] ms);
    return TIMER_W'(ms) * TIMER_W'(US_PER_MS);
  endfunction

endpackage

// ===== src/hrse_cfg.sv =====
module hrse_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hrse_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [hrse_pkg::CFG_DATA_W-1:0]     cfg_data,
  output hrse_pkg::cfg_t                      cfg
);

  logic                              enabled;
  logic [hrse_pkg::FACTOR_W-1:0]     slow_scale;
  logic [hrse_pkg::TIMER_W-1:0]      hold_us;
  logic [hrse_pkg::TIMER_W-1:0]      ramp_us;
  logic [hrse_pkg::STRENGTH_W-1:0]   threshold;
  logic [hrse_pkg::FACTOR_W-1:0]     scale_sat;
  logic [hrse_pkg::MS_W-1:0]         ramp_fixed;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_data < hrse_pkg::SCALE_MIN) begin
      scale_sat = hrse_pkg::SCALE_MIN;
    end else if (cfg_data > hrse_pkg::Q_ONE) begin
      scale_sat = hrse_pkg::Q_ONE;
    end else begin
      scale_sat = cfg_data;
    end
    ramp_fixed = (cfg_data[hrse_pkg::MS_W-1:0] == '0) ? hrse_pkg::MS_W'(1)
                                                      : cfg_data[hrse_pkg::MS_W-1:0];
  end

  // durations kept in microseconds, converted once at write time
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled    <= 1'b0;
      slow_scale <= hrse_pkg::SCALE_RESET;
      hold_us    <= hrse_pkg::us_from_ms(hrse_pkg::HOLD_MS_RESET);
      ramp_us    <= hrse_pkg::us_from_ms(hrse_pkg::RAMP_MS_RESET);
      threshold  <= hrse_pkg::THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hrse_pkg::REG_ENABLED:    enabled    <= cfg_data[0];
        hrse_pkg::REG_SLOW_SCALE: slow_scale <= scale_sat;
        hrse_pkg::REG_HOLD_TIME:  hold_us    <= hrse_pkg::us_from_ms(cfg_data[hrse_pkg::MS_W-1:0]);
        hrse_pkg::REG_RAMP_TIME:  ramp_us    <= hrse_pkg::us_from_ms(ramp_fixed);
        hrse_pkg::REG_THRESHOLD:  threshold  <= cfg_data[hrse_pkg::STRENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.enabled    = enabled;
    cfg.slow_scale = slow_scale;
    cfg.hold_us    = hold_us;
    cfg.ramp_us    = ramp_us;
    cfg.threshold  = threshold;
  end

endmodule

// ===== src/hrse_div.sv =====
module hrse_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [hrse_pkg::PROD_W-1:0]       dividend,
  input  logic [hrse_pkg::TIMER_W-1:0]      divisor,
  output logic                              done,
  output logic [hrse_pkg::QUOT_W-1:0]       quotient
);

  localparam int unsigned CNT_W = $clog2(hrse_pkg::QUOT_W);

  logic                               busy;
  logic [CNT_W-1:0]                   count;
  logic [hrse_pkg::TIMER_W-1:0]       rem;
  logic [hrse_pkg::TIMER_W-1:0]       dvs;
  logic [hrse_pkg::QUOT_W-1:0]        lo;
  logic [hrse_pkg::TIMER_W:0]         rem_sh;
  logic [hrse_pkg::TIMER_W:0]         rem_diff;
  logic                               fits;

  // restoring division, one quotient bit per cycle; dividend high half < divisor
  always_comb begin
    rem_sh   = {rem, lo[hrse_pkg::QUOT_W-1]};
    rem_diff = rem_sh - {1'b0, dvs};
    fits     = (rem_sh >= {1'b0, dvs});
  end

  assign quotient = lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        rem   <= dividend[hrse_pkg::PROD_W-1:hrse_pkg::QUOT_W];
        lo    <= dividend[hrse_pkg::QUOT_W-1:0];
        dvs   <= divisor;
      end else if (busy) begin
        rem   <= fits ? rem_diff[hrse_pkg::TIMER_W-1:0] : rem_sh[hrse_pkg::TIMER_W-1:0];
        lo    <= {lo[hrse_pkg::QUOT_W-2:0], fits};
        count <= count + CNT_W'(1);
        if (count == CNT_W'(hrse_pkg::QUOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/hold_ramp_slowdown_envelope.sv =====
// A trigger or a hold/idle tick passes ST_EXEC, then ST_FIN; a ramp tick passes ST_MUL,
// ST_LOAD and the 16-step serial divider (ST_DIV) for the ramp fraction before ST_FIN.
// One transaction at a time: the next is taken only after the result is registered;
// in_stall is high until the result is registered, longer while out_stall holds it.
// A finished result waits in the output register while the next transaction is taken.
// Reset (rst, synchronous): timers cleared, factor 1.0, registers to their defaults.
module hold_ramp_slowdown_envelope (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                op,
  input  logic [hrse_pkg::ELAPSED_W-1:0]      elapsed_us,
  input  logic [hrse_pkg::STRENGTH_W-1:0]     trigger_strength,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [hrse_pkg::FACTOR_W-1:0]       speed_factor,
  output logic [hrse_pkg::FACTOR_W-1:0]       slowdown_amount,
  output logic [hrse_pkg::PHASE_W-1:0]        phase,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hrse_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [hrse_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t                            state;
  hrse_pkg::cfg_t                    cfg;
  logic                              op_q;
  logic [hrse_pkg::TICK_W-1:0]       tick_us;
  logic [hrse_pkg::STRENGTH_W-1:0]   strength_q;
  logic [hrse_pkg::TIMER_W-1:0]      hold_left;
  logic [hrse_pkg::TIMER_W-1:0]      ramp_left;
  logic [hrse_pkg::FACTOR_W-1:0]     factor_now;
  logic [hrse_pkg::PROD_W-1:0]       prod;
  logic                              div_start;
  logic                              div_done;
  logic [hrse_pkg::QUOT_W-1:0]       div_quot;
  logic [hrse_pkg::TIMER_W-1:0]      tick_ext;
  logic [hrse_pkg::TIMER_W-1:0]      ramp_rem;
  logic [hrse_pkg::TIMER_W-1:0]      ramp_done;
  logic [hrse_pkg::FACTOR_W-1:0]     rise_span;
  logic [hrse_pkg::FACTOR_W:0]       factor_sum;
  logic [hrse_pkg::PHASE_W-1:0]      phase_next;
  logic                              out_free;

  hrse_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  hrse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (cfg.ramp_us),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign in_stall  = (state != ST_IDLE);
  assign div_start = (state == ST_LOAD);
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    tick_ext   = hrse_pkg::TIMER_W'(tick_us);
    ramp_rem   = (ramp_left > cfg.ramp_us) ? cfg.ramp_us : ramp_left;
    ramp_done  = cfg.ramp_us - ramp_rem;
    rise_span  = hrse_pkg::Q_ONE - cfg.slow_scale;
    factor_sum = (hrse_pkg::FACTOR_W + 1)'(cfg.slow_scale)
               + (hrse_pkg::FACTOR_W + 1)'(div_quot);
    if (hold_left != '0) begin
      phase_next = hrse_pkg::PHASE_HOLD;
    end else if (ramp_left != '0) begin
      phase_next = hrse_pkg::PHASE_RAMP;
    end else begin
      phase_next = hrse_pkg::PHASE_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      hold_left  <= '0;
      ramp_left  <= '0;
      factor_now <= hrse_pkg::Q_ONE;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op_q       <= op;
            tick_us    <= (elapsed_us > hrse_pkg::LONG_TICK_US) ? '0
                                                                : elapsed_us[hrse_pkg::TICK_W-1:0];
            strength_q <= trigger_strength;
            state      <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_FIN;
          if (op_q == hrse_pkg::OP_TRIGGER) begin
            if (cfg.enabled && strength_q >= cfg.threshold) begin
              hold_left <= cfg.hold_us;
              ramp_left <= cfg.ramp_us;
            end
          end else if (hold_left != '0) begin
            hold_left  <= (hold_left > tick_ext) ? hold_left - tick_ext : '0;
            factor_now <= cfg.slow_scale;
          end else if (ramp_left != '0) begin
            ramp_left <= (ramp_left > tick_ext) ? ramp_left - tick_ext : '0;
            state     <= ST_MUL;
          end else begin
            factor_now <= hrse_pkg::Q_ONE;
          end
        end
        ST_MUL: begin
          prod  <= hrse_pkg::PROD_W'(rise_span) * hrse_pkg::PROD_W'(ramp_done);
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            factor_now <= (factor_sum > (hrse_pkg::FACTOR_W + 1)'(hrse_pkg::Q_ONE))
                        ? hrse_pkg::Q_ONE : factor_sum[hrse_pkg::FACTOR_W-1:0];
            state      <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            speed_factor    <= factor_now;
            slowdown_amount <= hrse_pkg::Q_ONE - factor_now;
            phase           <= phase_next;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
